### hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the compare channel system timer: request
// and response bundles, operation codes and register offsets.
// ----------------------------------------------------------------------------
package cst_pkg;

  // payload widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FLAG_W = 4;

  // parameter defaults
  localparam int unsigned CHANNELS_DEF      = 4;
  localparam int unsigned PRESCALE_BITS_DEF = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // register map
  localparam logic [ADDR_W-1:0] OFF_CONTROL = 8'h00;
  localparam logic [ADDR_W-1:0] OFF_COUNT   = 8'h04;
  localparam logic [3:0]        SUB_CTRL    = 4'h0;
  localparam logic [3:0]        SUB_FLAG    = 4'h4;
  localparam logic [3:0]        SUB_CMP     = 4'h8;

  // control register fields
  localparam int unsigned CTRL_TEN  = 0;
  localparam int unsigned CTRL_FRZ  = 1;
  localparam int unsigned CPS_SHIFT = 8;

  // one request as it travels from the input stage to the core
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } req_t;

  // one response as it travels from the core to the result stage
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic [FLAG_W-1:0] flags;
  } rsp_t;

endpackage

### hdl/cst_core.sv
// ----------------------------------------------------------------------------
// cst_core
// Timer state, compare channels and register decode. Executes one request
// per cycle when exec_i is high and gives the response as seen after it.
// ----------------------------------------------------------------------------
module cst_core #(
  parameter int unsigned CHANNELS      = cst_pkg::CHANNELS_DEF,
  parameter int unsigned PRESCALE_BITS = cst_pkg::PRESCALE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          exec_i,
  input  cst_pkg::req_t req_i,
  output cst_pkg::rsp_t rsp_o
);

  // architectural state
  logic [cst_pkg::DATA_W-1:0] cnt_q, cnt_d;
  logic [PRESCALE_BITS-1:0]   pcnt_q, pcnt_d;
  logic [PRESCALE_BITS-1:0]   pset_q, pset_d;
  logic                       ten_q, ten_d;
  logic                       frz_q, frz_d;
  logic [CHANNELS-1:0]        ch_en_q, ch_en_d;
  logic [CHANNELS-1:0]        flag_q, flag_d;
  logic [cst_pkg::DATA_W-1:0] cmp_q [CHANNELS];
  logic [cst_pkg::DATA_W-1:0] cmp_d [CHANNELS];

  logic [CHANNELS-1:0]                 ch_hit;
  logic [cst_pkg::DATA_W-1:0]          rd_data;
  logic [CHANNELS-1:0]                 active;
  logic [CHANNELS+cst_pkg::FLAG_W-1:0] active_ext;

  // channel n sits in the address window starting at 0x10 + 16n
  always_comb begin
    for (int n = 0; n < CHANNELS; n++) begin
      ch_hit[n] = (req_i.addr[7:4] == 4'(n + 1));
    end
  end

  // register read mux
  always_comb begin
    rd_data = '0;
    if (req_i.addr == cst_pkg::OFF_CONTROL) begin
      rd_data[cst_pkg::CTRL_TEN] = ten_q;
      rd_data[cst_pkg::CTRL_FRZ] = frz_q;
      rd_data[cst_pkg::CPS_SHIFT +: PRESCALE_BITS] = pset_q;
    end else if (req_i.addr == cst_pkg::OFF_COUNT) begin
      rd_data = cnt_q;
    end else begin
      for (int n = 0; n < CHANNELS; n++) begin
        if (ch_hit[n]) begin
          unique case (req_i.addr[3:0])
            cst_pkg::SUB_CTRL: rd_data = {{(cst_pkg::DATA_W-1){1'b0}}, ch_en_q[n]};
            cst_pkg::SUB_FLAG: rd_data = {{(cst_pkg::DATA_W-1){1'b0}}, flag_q[n]};
            cst_pkg::SUB_CMP:  rd_data = cmp_q[n];
            default:           rd_data = '0;
          endcase
        end
      end
    end
  end

  // next state for the current request
  always_comb begin
    cnt_d   = cnt_q;
    pcnt_d  = pcnt_q;
    pset_d  = pset_q;
    ten_d   = ten_q;
    frz_d   = frz_q;
    ch_en_d = ch_en_q;
    flag_d  = flag_q;
    for (int n = 0; n < CHANNELS; n++) begin
      cmp_d[n] = cmp_q[n];
    end
    unique case (req_i.op)
      cst_pkg::OP_TICK: begin
        if (ten_q) begin
          // prescale period over: count up and check compares
          if (pcnt_q >= pset_q) begin
            pcnt_d = '0;
            cnt_d  = cnt_q + 32'd1;
            for (int n = 0; n < CHANNELS; n++) begin
              if (ch_en_q[n] && (cmp_q[n] == cnt_d)) begin
                flag_d[n] = 1'b1;
              end
            end
          end else begin
            pcnt_d = pcnt_q + PRESCALE_BITS'(1);
          end
        end
      end
      cst_pkg::OP_WRITE: begin
        if (req_i.addr == cst_pkg::OFF_CONTROL) begin
          ten_d  = req_i.data[cst_pkg::CTRL_TEN];
          frz_d  = req_i.data[cst_pkg::CTRL_FRZ];
          pset_d = req_i.data[cst_pkg::CPS_SHIFT +: PRESCALE_BITS];
        end else if (req_i.addr == cst_pkg::OFF_COUNT) begin
          cnt_d = req_i.data;
        end else begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (ch_hit[n]) begin
              unique case (req_i.addr[3:0])
                cst_pkg::SUB_CTRL: ch_en_d[n] = req_i.data[0];
                // write one to clear
                cst_pkg::SUB_FLAG: begin
                  if (req_i.data[0]) begin
                    flag_d[n] = 1'b0;
                  end
                end
                cst_pkg::SUB_CMP:  cmp_d[n] = req_i.data;
                default: ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase
  end

  // state registers, updated once per executed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pcnt_q  <= '0;
      pset_q  <= '0;
      ten_q   <= 1'b0;
      frz_q   <= 1'b0;
      ch_en_q <= '0;
      flag_q  <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        cmp_q[n] <= '0;
      end
    end else if (exec_i) begin
      cnt_q   <= cnt_d;
      pcnt_q  <= pcnt_d;
      pset_q  <= pset_d;
      ten_q   <= ten_d;
      frz_q   <= frz_d;
      ch_en_q <= ch_en_d;
      flag_q  <= flag_d;
      for (int n = 0; n < CHANNELS; n++) begin
        cmp_q[n] <= cmp_d[n];
      end
    end
  end

  // interrupt status after the request; only the low channels get a flag bit
  assign active     = ch_en_d & flag_d;
  assign active_ext = {{cst_pkg::FLAG_W{1'b0}}, active};

  always_comb begin
    rsp_o.read_data = (req_i.op == cst_pkg::OP_READ) ? rd_data : '0;
    rsp_o.irq       = |active;
    rsp_o.flags     = active_ext[cst_pkg::FLAG_W-1:0];
  end

endmodule

### hdl/compare_channel_system_timer_top.sv
// ----------------------------------------------------------------------------
// compare_channel_system_timer_top
// System timer with a prescaled 32-bit up-counter and compare channels,
// driven by a request stream of ticks, register reads and register writes.
//
//   channel | direction | fields                              | handshake
//   --------+-----------+-------------------------------------+-----------------
//   in      | input     | operation, address, write_data      | in_valid/ready
//   out     | output    | read_data, irq_line, channel_flags  | out_valid/ready
//
// One request per clock cycle sustained while out_ready is high; a response
// becomes valid in the result register, after passing the input register.
// The core state updates as a request moves from the input register into
// the result register, so requests execute strictly in order.
// A stalled output holds the result register and then the input register;
// in_ready drops only while both are full.
// Reset clears the timer, prescaler, control bits and all channels at once.
// ----------------------------------------------------------------------------
module compare_channel_system_timer_top #(
  parameter int unsigned CHANNELS      = cst_pkg::CHANNELS_DEF,
  parameter int unsigned PRESCALE_BITS = cst_pkg::PRESCALE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cst_pkg::OP_W-1:0]    operation_i,
  input  logic [cst_pkg::ADDR_W-1:0]  address_i,
  input  logic [cst_pkg::DATA_W-1:0]  write_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cst_pkg::DATA_W-1:0]  read_data_o,
  output logic                        irq_line_o,
  output logic [cst_pkg::FLAG_W-1:0]  channel_flags_o
);

  logic          req_valid_q;
  cst_pkg::req_t req_q;
  logic          rsp_valid_q;
  cst_pkg::rsp_t rsp_q;
  cst_pkg::rsp_t rsp_d;
  logic          exec;

  // a request executes when the result register is free or being emptied
  assign exec       = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || exec;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q.op   <= operation_i;
      req_q.addr <= address_i;
      req_q.data <= write_data_i;
    end
  end

  cst_core #(
    .CHANNELS      (CHANNELS),
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (!rsp_valid_q || out_ready_i) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o     = rsp_valid_q;
  assign read_data_o     = rsp_q.read_data;
  assign irq_line_o      = rsp_q.irq;
  assign channel_flags_o = rsp_q.flags;

endmodule

### hdl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the system timer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [cst_pkg::DATA_W-1:0]  read_data_o,
  input logic                        irq_line_o,
  input logic [cst_pkg::FLAG_W-1:0]  channel_flags_o
);

  // a waiting request stays offered until taken
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("request withdrawn while stalled");

  // a pending response stays until taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // a stalled response keeps its data
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(read_data_o) && $stable(irq_line_o))
    else $error("response changed while stalled");

  // any flagged enabled channel must raise the interrupt line
  a_irq_or : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (channel_flags_o != '0) |-> irq_line_o)
    else $error("irq line low with channel flags set");

  // with the result register empty the block never back-pressures
  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind compare_channel_system_timer_top cst_checker u_cst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_data_o     (read_data_o),
  .irq_line_o      (irq_line_o),
  .channel_flags_o (channel_flags_o)
);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the compare channel system timer. A scoreboard
// class predicts each response from the requests taken on the input channel
// and checks responses in order; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_CH    = cst_pkg::CHANNELS_DEF;
  localparam int unsigned PS_BITS   = cst_pkg::PRESCALE_BITS_DEF;
  localparam logic [cst_pkg::OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [cst_pkg::ADDR_W-1:0] CH_BASE   = 8'h10;
  localparam int unsigned                CH_STRIDE = 16;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_SHOWN    = 10;

  typedef struct {
    logic [cst_pkg::DATA_W-1:0] read_data;
    logic                       irq;
    logic [cst_pkg::FLAG_W-1:0] flags;
  } timer_rsp_t;

  // predicts the timer response to every request and checks the outputs
  class timer_scoreboard;
    logic [cst_pkg::DATA_W-1:0] timer_value;
    logic [PS_BITS-1:0]         presc_cnt;
    logic [PS_BITS-1:0]         presc_set;
    bit                         run_en;
    bit                         frz_bit;
    bit                         ch_en[NUM_CH];
    logic [cst_pkg::DATA_W-1:0] ch_cmp[NUM_CH];
    bit                         ch_flag[NUM_CH];
    timer_rsp_t                 expected_rsp_q[$];
    int                         mismatches;

    function new();
      timer_value = '0;
      presc_cnt   = '0;
      presc_set   = '0;
      run_en      = 0;
      frz_bit     = 0;
      for (int n = 0; n < NUM_CH; n++) begin
        ch_en[n]   = 0;
        ch_cmp[n]  = '0;
        ch_flag[n] = 0;
      end
      mismatches = 0;
    endfunction

    // one module clock tick through the prescaler
    function void advance_timer();
      if (!run_en) return;
      if (presc_cnt >= presc_set) begin
        presc_cnt   = '0;
        timer_value = timer_value + 1;
        for (int n = 0; n < NUM_CH; n++)
          if (ch_en[n] && ch_cmp[n] == timer_value) ch_flag[n] = 1;
      end else begin
        presc_cnt = presc_cnt + 1;
      end
    endfunction

    // channel register decode, false when unmapped
    function bit decode_channel(input logic [cst_pkg::ADDR_W-1:0] addr, output int ch,
                                output logic [3:0] sub);
      ch  = 0;
      sub = addr[3:0];
      if (addr < CH_BASE) return 0;
      ch = (int'(addr) - int'(CH_BASE)) / CH_STRIDE;
      if (ch >= NUM_CH) return 0;
      return sub == cst_pkg::SUB_CTRL || sub == cst_pkg::SUB_FLAG ||
             sub == cst_pkg::SUB_CMP;
    endfunction

    function logic [cst_pkg::DATA_W-1:0] read_register(
      input logic [cst_pkg::ADDR_W-1:0] addr);
      logic [cst_pkg::DATA_W-1:0] value;
      logic [3:0]                 sub;
      int                         ch;
      value = '0;
      if (addr == cst_pkg::OFF_CONTROL) begin
        value[cst_pkg::CTRL_TEN] = run_en;
        value[cst_pkg::CTRL_FRZ] = frz_bit;
        value[cst_pkg::CPS_SHIFT +: PS_BITS] = presc_set;
      end else if (addr == cst_pkg::OFF_COUNT) begin
        value = timer_value;
      end else if (decode_channel(addr, ch, sub)) begin
        if (sub == cst_pkg::SUB_CTRL) value[0] = ch_en[ch];
        else if (sub == cst_pkg::SUB_FLAG) value[0] = ch_flag[ch];
        else value = ch_cmp[ch];
      end
      return value;
    endfunction

    function void write_register(input logic [cst_pkg::ADDR_W-1:0] addr,
                                 input logic [cst_pkg::DATA_W-1:0] data);
      logic [3:0] sub;
      int         ch;
      if (addr == cst_pkg::OFF_CONTROL) begin
        run_en    = data[cst_pkg::CTRL_TEN];
        frz_bit   = data[cst_pkg::CTRL_FRZ];
        presc_set = data[cst_pkg::CPS_SHIFT +: PS_BITS];
      end else if (addr == cst_pkg::OFF_COUNT) begin
        timer_value = data;
      end else if (decode_channel(addr, ch, sub)) begin
        if (sub == cst_pkg::SUB_CTRL) ch_en[ch] = data[0];
        else if (sub == cst_pkg::SUB_FLAG) begin
          // write one to clear
          if (data[0]) ch_flag[ch] = 0;
        end else ch_cmp[ch] = data;
      end
    endfunction

    // apply one accepted request and queue its response
    function void note_request(input logic [cst_pkg::OP_W-1:0] op,
                               input logic [cst_pkg::ADDR_W-1:0] addr,
                               input logic [cst_pkg::DATA_W-1:0] data);
      timer_rsp_t rsp;
      rsp.read_data = '0;
      rsp.irq       = 0;
      rsp.flags     = '0;
      case (op)
        cst_pkg::OP_TICK:  advance_timer();
        cst_pkg::OP_READ:  rsp.read_data = read_register(addr);
        cst_pkg::OP_WRITE: write_register(addr, data);
        default: ;
      endcase
      for (int n = 0; n < NUM_CH; n++) begin
        if (ch_en[n] && ch_flag[n]) begin
          rsp.irq = 1;
          if (n < cst_pkg::FLAG_W) rsp.flags[n] = 1;
        end
      end
      expected_rsp_q.push_back(rsp);
    endfunction

    // compare one accepted response with the oldest prediction
    function void check_response(input logic [cst_pkg::DATA_W-1:0] rd, input logic irq,
                                 input logic [cst_pkg::FLAG_W-1:0] flags);
      timer_rsp_t exp_rsp;
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected response rd=%h irq=%b flags=%b", rd, irq, flags);
        return;
      end
      exp_rsp = expected_rsp_q.pop_front();
      if (rd !== exp_rsp.read_data || irq !== exp_rsp.irq || flags !== exp_rsp.flags) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch: expected rd=%h irq=%b flags=%b, got rd=%h irq=%b flags=%b",
                   exp_rsp.read_data, exp_rsp.irq, exp_rsp.flags, rd, irq, flags);
      end
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [cst_pkg::OP_W-1:0]   operation_i;
  logic [cst_pkg::ADDR_W-1:0] address_i;
  logic [cst_pkg::DATA_W-1:0] write_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [cst_pkg::DATA_W-1:0] read_data_o;
  logic                       irq_line_o;
  logic [cst_pkg::FLAG_W-1:0] channel_flags_o;

  timer_scoreboard sb;
  int unsigned     cycles;
  bit              send_burst;
  bit              recv_burst;

  compare_channel_system_timer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .irq_line_o      (irq_line_o),
    .channel_flags_o (channel_flags_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one request: random idle gap, then hold valid until taken
  task automatic send_request(input logic [cst_pkg::OP_W-1:0] op,
                              input logic [cst_pkg::ADDR_W-1:0] addr,
                              input logic [cst_pkg::DATA_W-1:0] data);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_request(op, addr, data);
  endtask

  // mostly mapped offsets, sometimes any byte offset
  function automatic logic [cst_pkg::ADDR_W-1:0] pick_address();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return cst_pkg::OFF_CONTROL;
    if (sel < 3) return cst_pkg::OFF_COUNT;
    if (sel < 8) begin
      case ($urandom_range(0, 2))
        0: return CH_BASE + cst_pkg::ADDR_W'(CH_STRIDE * $urandom_range(0, NUM_CH - 1))
                  + cst_pkg::SUB_CTRL;
        1: return CH_BASE + cst_pkg::ADDR_W'(CH_STRIDE * $urandom_range(0, NUM_CH - 1))
                  + cst_pkg::SUB_FLAG;
        default:
          return CH_BASE + cst_pkg::ADDR_W'(CH_STRIDE * $urandom_range(0, NUM_CH - 1))
                 + cst_pkg::SUB_CMP;
      endcase
    end
    return cst_pkg::ADDR_W'($urandom_range(0, 255));
  endfunction

  // response side: random stalls, check every taken response
  initial begin
    int stall;
    out_ready_i = 1'b0;
    recv_burst  = 0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      sb.check_response(read_data_o, irq_line_o, channel_flags_o);
    end
  end

  // request side and end of run
  initial begin
    logic [cst_pkg::OP_W-1:0]   op;
    logic [cst_pkg::ADDR_W-1:0] addr;
    logic [cst_pkg::DATA_W-1:0] data;
    int                         sel;
    int                         ch;
    sb           = new();
    send_burst   = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = cst_pkg::OP_TICK;
    address_i    = '0;
    write_data_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values, unmapped read
    send_request(cst_pkg::OP_READ, cst_pkg::OFF_CONTROL, '0);
    send_request(cst_pkg::OP_READ, 8'hFF, '1);
    // compare hit at all-ones and again on wrap to zero
    send_request(cst_pkg::OP_WRITE, cst_pkg::OFF_COUNT, 32'hFFFF_FFFE);
    send_request(cst_pkg::OP_WRITE, CH_BASE + cst_pkg::SUB_CMP, 32'hFFFF_FFFF);
    send_request(cst_pkg::OP_WRITE, CH_BASE + 8'h10 + cst_pkg::SUB_CMP, 32'h0);
    send_request(cst_pkg::OP_WRITE, CH_BASE + cst_pkg::SUB_CTRL, 32'h1);
    send_request(cst_pkg::OP_WRITE, CH_BASE + 8'h10 + cst_pkg::SUB_CTRL, 32'hFFFF_FFFF);
    send_request(cst_pkg::OP_WRITE, cst_pkg::OFF_CONTROL, 32'h0000_0003);
    send_request(cst_pkg::OP_TICK, 8'h00, 32'h0);
    send_request(cst_pkg::OP_TICK, 8'hFF, 32'hFFFF_FFFF);
    // flag readback and write-one-to-clear, zero write leaves it
    send_request(cst_pkg::OP_READ, CH_BASE + cst_pkg::SUB_FLAG, '0);
    send_request(cst_pkg::OP_WRITE, CH_BASE + cst_pkg::SUB_FLAG, 32'hFFFF_FFFE);
    send_request(cst_pkg::OP_WRITE, CH_BASE + cst_pkg::SUB_FLAG, 32'h1);
    send_request(cst_pkg::OP_WRITE, CH_BASE + 8'h30 + cst_pkg::SUB_CMP, 32'hFFFF_FFFF);
    send_request(cst_pkg::OP_READ, CH_BASE + 8'h30 + cst_pkg::SUB_CMP, '0);
    // unaligned, hole and out-of-range channel offsets, unused opcode
    send_request(cst_pkg::OP_WRITE, CH_BASE + cst_pkg::SUB_CMP + 8'h1, 32'h1234_5678);
    send_request(cst_pkg::OP_READ, CH_BASE + 8'hC, '0);
    send_request(cst_pkg::OP_WRITE, CH_BASE + 8'h40 + cst_pkg::SUB_CMP, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, cst_pkg::OFF_COUNT, 32'hFFFF_FFFF);
    // largest prescale, then lowered below the running prescale count
    send_request(cst_pkg::OP_WRITE, cst_pkg::OFF_CONTROL, 32'hFFFF_FF01);
    repeat (3) send_request(cst_pkg::OP_TICK, 8'h00, 32'h0);
    send_request(cst_pkg::OP_WRITE, cst_pkg::OFF_CONTROL, 32'h0000_0201);
    send_request(cst_pkg::OP_TICK, 8'h00, 32'h0);
    send_request(cst_pkg::OP_READ, cst_pkg::OFF_COUNT, '0);
    // stopped timer holds, disabled channel keeps its raw flag off the interrupt
    send_request(cst_pkg::OP_WRITE, cst_pkg::OFF_CONTROL, 32'h0);
    send_request(cst_pkg::OP_TICK, 8'h00, 32'h0);
    send_request(cst_pkg::OP_WRITE, CH_BASE + 8'h10 + cst_pkg::SUB_CTRL, 32'h0);
    send_request(cst_pkg::OP_READ, CH_BASE + 8'h10 + cst_pkg::SUB_FLAG, '0);

    // random traffic, biased toward compare hits
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // let everything drain once mid-run
      if (i == RANDOM_ITEMS / 2) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      sel  = $urandom_range(0, 99);
      addr = cst_pkg::ADDR_W'($urandom);
      data = $urandom;
      if (sel < 45) begin
        op = cst_pkg::OP_TICK;
      end else if (sel < 65) begin
        op   = cst_pkg::OP_READ;
        addr = pick_address();
      end else if (sel < 93) begin
        op   = cst_pkg::OP_WRITE;
        addr = pick_address();
        ch   = $urandom_range(0, NUM_CH - 1);
        if (addr == cst_pkg::OFF_CONTROL) begin
          data[cst_pkg::CTRL_TEN] = ($urandom_range(0, 7) != 0);
          if ($urandom_range(0, 7) != 0)
            data[cst_pkg::CPS_SHIFT +: PS_BITS] = PS_BITS'($urandom_range(0, 3));
        end else if (addr == cst_pkg::OFF_COUNT) begin
          case ($urandom_range(0, 2))
            0: data = sb.ch_cmp[ch] - $urandom_range(0, 5);
            1: data = 32'hFFFF_FFFF - $urandom_range(0, 5);
            default: ;
          endcase
        end else if (addr[3:0] == cst_pkg::SUB_CTRL) begin
          data[0] = ($urandom_range(0, 3) != 0);
        end else if (addr[3:0] == cst_pkg::SUB_CMP && $urandom_range(0, 3) != 0) begin
          data = sb.timer_value + $urandom_range(0, 6);
        end
      end else begin
        op = OP_UNUSED;
      end
      send_request(op, addr, data);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then wait for stray responses
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
